[hw/rtl/tal_pkg.sv]
// Shared constants, widths and the arctangent table for the tilt angle filter.
package tal_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int ANGLE_ITER_DEF    = 16;
  localparam int RAW_W             = 16;
  localparam int ALPHA_W           = 16;
  localparam int ANGLE_W           = 8;
  localparam int ANGLE_FRAC        = 20;
  localparam int Z_W               = 30;
  localparam int ATAN_ENTRIES      = 24;
  localparam int ONE_G_COUNTS      = 16000;
  localparam int DEG_MAX           = 180;
  localparam int DEG_RIGHT         = 90;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd3277;

  // atan(2^-i) in degrees, 20 fraction bits, rounded
  function automatic logic signed [Z_W-1:0] atan_q20(input logic [4:0] idx);
    logic signed [Z_W-1:0] v;
    begin
      case (idx)
        5'd0:    v = 30'sd47185920;
        5'd1:    v = 30'sd27855475;
        5'd2:    v = 30'sd14718068;
        5'd3:    v = 30'sd7471121;
        5'd4:    v = 30'sd3750058;
        5'd5:    v = 30'sd1876857;
        5'd6:    v = 30'sd938658;
        5'd7:    v = 30'sd469357;
        5'd8:    v = 30'sd234682;
        5'd9:    v = 30'sd117342;
        5'd10:   v = 30'sd58671;
        5'd11:   v = 30'sd29335;
        5'd12:   v = 30'sd14668;
        5'd13:   v = 30'sd7334;
        5'd14:   v = 30'sd3667;
        5'd15:   v = 30'sd1833;
        5'd16:   v = 30'sd917;
        5'd17:   v = 30'sd458;
        5'd18:   v = 30'sd229;
        5'd19:   v = 30'sd115;
        5'd20:   v = 30'sd57;
        5'd21:   v = 30'sd29;
        5'd22:   v = 30'sd14;
        5'd23:   v = 30'sd7;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

[hw/rtl/tal_if.sv]
// Valid/ready channel interfaces for samples and results.
interface tal_in_if import tal_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [RAW_W-1:0]  x_raw;
  logic signed [RAW_W-1:0]  y_raw;
  logic signed [RAW_W-1:0]  z_raw;
  modport source (output valid, x_raw, y_raw, z_raw, input ready);
  modport sink   (input valid, x_raw, y_raw, z_raw, output ready);
endinterface

interface tal_out_if import tal_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [RAW_W-1:0]  x_filtered;
  logic signed [RAW_W-1:0]  y_filtered;
  logic signed [RAW_W-1:0]  z_filtered;
  logic [ANGLE_W-1:0]       down_angle_deg;
  logic                     zero_vector;
  modport source (output valid, x_filtered, y_filtered, z_filtered, down_angle_deg,
                  zero_vector, input ready);
  modport sink   (input valid, x_filtered, y_filtered, z_filtered, down_angle_deg,
                  zero_vector, output ready);
endinterface

[hw/rtl/tal_mul.sv]
// Shared signed multiplier with registered product.
module tal_mul #(
  parameter int W = 33
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p_r
);
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule

[hw/rtl/tal_isqrt.sv]
// Bit-serial integer square root, two radicand bits per cycle.
module tal_isqrt #(
  parameter int IN_W = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [IN_W-1:0]      n,
  output logic                 done_r,
  output logic [IN_W/2-1:0]    root
);
  logic [IN_W-1:0] rem_r, rem_nxt;
  logic [IN_W-1:0] res_r, res_nxt;
  logic [IN_W-1:0] bit_r, bit_nxt;
  logic [IN_W:0]   trial;

  assign trial = {1'b0, res_r} + {1'b0, bit_r};
  assign root  = res_r[IN_W/2-1:0];

  always_comb begin
    rem_nxt = rem_r;
    res_nxt = res_r;
    bit_nxt = bit_r;
    if (start) begin
      rem_nxt = n;
      res_nxt = '0;
      bit_nxt = {2'b01, {(IN_W-2){1'b0}}};
    end else if (bit_r != '0) begin
      if ({1'b0, rem_r} >= trial) begin
        rem_nxt = rem_r - trial[IN_W-1:0];
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    if (!rst_n) begin
      bit_r  <= '0;
      done_r <= 1'b0;
    end else begin
      bit_r  <= bit_nxt;
      done_r <= !start && (bit_r != '0) && (bit_nxt == '0);
    end
  end
endmodule

[hw/rtl/tal_cordic.sv]
// Vectoring CORDIC, one micro-rotation per cycle, angle in degrees.
module tal_cordic import tal_pkg::*; #(
  parameter int CW    = 36,
  parameter int ITER  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [CW-1:0]  x0,
  input  logic signed [CW-1:0]  y0,
  input  logic signed [Z_W-1:0] z0,
  output logic                  done_r,
  output logic signed [Z_W-1:0] z_r
);
  localparam int CNT_W = $clog2(ITER + 1);

  logic signed [CW-1:0] x_r, y_r, dx, dy;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;

  assign dx = y_r >>> cnt_r;
  assign dy = x_r >>> cnt_r;

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x0;
      y_r <= y0;
      z_r <= z0;
    end else if (busy_r) begin
      if (y_r >= 0) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + atan_q20(5'(cnt_r));
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - atan_q20(5'(cnt_r));
      end
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ITER - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

[hw/rtl/tilt_angle_lowpass_filter.sv]
// Top level: three-axis low-pass filter and tilt angle sequencer.
//
//  channel  | dir | payload                                             | handshake
//  ---------+-----+-----------------------------------------------------+-----------
//  in_ch    | in  | x_raw, y_raw, z_raw (s16 counts)                    | valid/ready
//  out_ch   | out | x/y/z_filtered (s16), down_angle_deg (u8), zero_vec | valid/ready
//  cfg_     | in  | cfg_wdata = alpha_q16 (u16, Q0.16)                  | cfg_we
//
// Each item passes through the filter steps, the squares, the bit-serial square root and
// the CORDIC loop (skipped when the angle needs no CORDIC) before the output state.
// One shared multiplier serves the three filter updates and the two squares.
// in_ch.ready is high only while idle; a finished result waits in the output register
// and the next item is taken meanwhile; while that register is full and not taken,
// the block waits in S_OUT. rst_n is synchronous: filter goes to (0,0,1 g).
module tilt_angle_lowpass_filter import tal_pkg::*; #(
  parameter int FRACTION_BITS    = FRACTION_BITS_DEF,
  parameter int ANGLE_ITERATIONS = ANGLE_ITER_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [ALPHA_W-1:0] cfg_wdata,
  tal_in_if.sink             in_ch,
  tal_out_if.source          out_ch
);
  localparam int SW = FRACTION_BITS + RAW_W;   // filter state width
  localparam int MW = SW + 1;                  // multiplier operand width
  localparam int CW = SW + 4;                  // CORDIC datapath width

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FILT = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_CORD = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]                state_r;
  logic [2:0]                step_r;
  logic [ALPHA_W-1:0]        alpha_r;
  logic signed [SW-1:0]      filt_r [3];
  logic signed [RAW_W-1:0]   raw_r [3];
  logic [2*SW-1:0]           sum_r;
  logic [SW-1:0]             r_r;
  logic [ANGLE_W-1:0]        angle_r;
  logic                      zero_r;
  logic                      out_valid_r;
  logic signed [RAW_W-1:0]   ox_r, oy_r, oz_r;
  logic [ANGLE_W-1:0]        oang_r;
  logic                      ozero_r;

  logic signed [MW-1:0]      mul_a, mul_b;
  logic signed [2*MW-1:0]    prod_r, prod_sh;
  logic [1:0]                axis;
  logic signed [SW-1:0]      target;
  logic [SW-1:0]             abs_y, abs_z;
  logic                      sqrt_start, sqrt_done;
  logic [SW-1:0]             sqrt_root;
  logic                      cord_start, cord_done;
  logic signed [CW-1:0]      cx0, cy0;
  logic signed [Z_W-1:0]     cz0, cz;
  logic signed [Z_W-ANGLE_FRAC-1:0] deg_raw;
  logic                      fx_neg, all_zero, out_load;

  assign axis     = step_r[2:1];
  assign target   = {raw_r[axis], {FRACTION_BITS{1'b0}}};
  assign abs_y    = filt_r[1][SW-1] ? SW'(-filt_r[1]) : SW'(filt_r[1]);
  assign abs_z    = filt_r[2][SW-1] ? SW'(-filt_r[2]) : SW'(filt_r[2]);
  assign prod_sh  = prod_r >>> ALPHA_W;
  assign fx_neg   = filt_r[0][SW-1];
  assign all_zero = (filt_r[0] == '0) && (filt_r[1] == '0) && (filt_r[2] == '0);

  // Feed the shared multiplier: alpha*diff while filtering, squares after.
  always_comb begin
    mul_a = {{(MW-ALPHA_W){1'b0}}, alpha_r};
    mul_b = MW'(target) - MW'(filt_r[axis]);
    if (state_r == S_SQ) begin
      if (step_r == 3'd0) begin
        mul_a = {1'b0, abs_y};
        mul_b = {1'b0, abs_y};
      end else begin
        mul_a = {1'b0, abs_z};
        mul_b = {1'b0, abs_z};
      end
    end
  end

  tal_mul #(.W(MW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod_r)
  );

  assign sqrt_start = (state_r == S_SQ) && (step_r == 3'd2);

  tal_isqrt #(.IN_W(2*SW)) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sqrt_start),
    .n      (sum_r + prod_r[2*SW-1:0]),
    .done_r (sqrt_done),
    .root   (sqrt_root)
  );

  // Pre-rotate by 90 degrees when fx is negative so the CORDIC stays in range.
  always_comb begin
    if (fx_neg) begin
      cx0 = CW'(r_r);
      cy0 = -CW'(filt_r[0]);
      cz0 = Z_W'(DEG_RIGHT) <<< ANGLE_FRAC;
    end else begin
      cx0 = CW'(filt_r[0]);
      cy0 = CW'(r_r);
      cz0 = '0;
    end
  end

  assign cord_start = (state_r == S_SQRT) && sqrt_done && !all_zero && (sqrt_root != '0)
                      && (filt_r[0] != '0);
  // cord_start comes before r_r holds the root, so launch from its registered copy instead
  logic cord_go_r;

  tal_cordic #(.CW(CW), .ITER(ANGLE_ITERATIONS)) u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cord_go_r),
    .x0     (cx0),
    .y0     (cy0),
    .z0     (cz0),
    .done_r (cord_done),
    .z_r    (cz)
  );

  assign deg_raw  = cz[Z_W-1:ANGLE_FRAC];
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      raw_r[0] <= in_ch.x_raw;
      raw_r[1] <= in_ch.y_raw;
      raw_r[2] <= in_ch.z_raw;
    end
    if (state_r == S_SQ && step_r == 3'd1) begin
      sum_r <= prod_r[2*SW-1:0];
    end
    if (sqrt_done) begin
      r_r <= sqrt_root;
    end
    if (out_load) begin
      ox_r    <= filt_r[0][SW-1 -: RAW_W];
      oy_r    <= filt_r[1][SW-1 -: RAW_W];
      oz_r    <= filt_r[2][SW-1 -: RAW_W];
      oang_r  <= angle_r;
      ozero_r <= zero_r;
    end

    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      alpha_r     <= ALPHA_RESET;
      filt_r[0]   <= '0;
      filt_r[1]   <= '0;
      filt_r[2]   <= SW'(ONE_G_COUNTS) <<< FRACTION_BITS;
      out_valid_r <= 1'b0;
      cord_go_r   <= 1'b0;
      angle_r     <= '0;
      zero_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        alpha_r <= cfg_wdata;
      end
      cord_go_r <= cord_start;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            state_r <= S_FILT;
            step_r  <= '0;
          end
        end
        S_FILT: begin
          // even step: multiply; odd step: fold the product into the axis state
          if (step_r[0]) begin
            filt_r[axis] <= filt_r[axis] + prod_sh[SW-1:0];
          end
          if (step_r == 3'd5) begin
            state_r <= S_SQ;
            step_r  <= '0;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_SQ: begin
          if (step_r == 3'd2) begin
            state_r <= S_SQRT;
            step_r  <= '0;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            zero_r <= all_zero;
            if (all_zero) begin
              angle_r <= '0;
              state_r <= S_OUT;
            end else if (sqrt_root == '0) begin
              angle_r <= fx_neg ? ANGLE_W'(DEG_MAX) : '0;
              state_r <= S_OUT;
            end else if (filt_r[0] == '0) begin
              angle_r <= ANGLE_W'(DEG_RIGHT);
              state_r <= S_OUT;
            end else begin
              state_r <= S_CORD;
            end
          end
        end
        S_CORD: begin
          if (cord_done) begin
            // clamp overshoot into 0..180
            if (deg_raw < 0) begin
              angle_r <= '0;
            end else if (deg_raw > (Z_W-ANGLE_FRAC)'(DEG_MAX)) begin
              angle_r <= ANGLE_W'(DEG_MAX);
            end else begin
              angle_r <= deg_raw[ANGLE_W-1:0];
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.x_filtered     = ox_r;
  assign out_ch.y_filtered     = oy_r;
  assign out_ch.z_filtered     = oz_r;
  assign out_ch.down_angle_deg = oang_r;
  assign out_ch.zero_vector    = ozero_r;

  a_rise_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result shown without finishing an item");

  a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ozero_r) |-> (oang_r == '0))
    else $error("zero vector with nonzero angle");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (oang_r <= ANGLE_W'(DEG_MAX)))
    else $error("angle above 180 degrees");

  a_cordic_only_in_cord: assert property (@(posedge clk) disable iff (!rst_n)
    cord_done |-> (state_r == S_CORD))
    else $error("CORDIC finished outside its phase");

endmodule

[verif/tb_top.sv]
// Testbench for the tilt angle low-pass filter: directed and random samples against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import tal_pkg::*;

  // One expected filter output, in the order the block must deliver it.
  typedef struct {
    logic signed [RAW_W-1:0] x_filt;
    logic signed [RAW_W-1:0] y_filt;
    logic signed [RAW_W-1:0] z_filt;
    logic [ANGLE_W-1:0]      angle;
    logic                    is_zero;
  } tilt_result_t;

  localparam int CYCLE_NS    = 20;
  localparam int SETTLE_CYCS = 80;   // a bit more than one item's processing time

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ALPHA_W-1:0] cfg_wdata;

  tal_in_if  in_ch();
  tal_out_if out_ch();

  tilt_angle_lowpass_filter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Predictor state: filter accumulators in raw-count units with 16 fraction bits.
  longint              acc_x, acc_y, acc_z;
  longint unsigned     alpha_now;
  tilt_result_t        pending_results[$];
  int                  fail_count;

  initial clk = 1'b0;
  always #(CYCLE_NS / 2) clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // Mostly back to back, sometimes a few cycles, rarely a long pause.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One pole update; >>> on a signed 64-bit value rounds toward minus infinity.
  function automatic longint lowpass(input longint acc, input logic signed [RAW_W-1:0] raw);
    longint target;
    target = longint'(raw) <<< FRACTION_BITS_DEF;
    return acc + ((longint'(alpha_now) * (target - acc)) >>> 16);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root, probe;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > n) probe = probe >> 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n = n - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Angle to +x in truncated degrees: square root of the yz part, then vectoring CORDIC.
  function automatic int down_angle(input longint fx, input longint fy, input longint fz);
    longint unsigned ay, az;
    longint r, cx, cy, cz, sx, sy, deg;
    ay = (fy < 0) ? -fy : fy;
    az = (fz < 0) ? -fz : fz;
    r = longint'(int_sqrt(ay * ay + az * az));
    if (r == 0) return (fx < 0) ? DEG_MAX : 0;
    if (fx == 0) return DEG_RIGHT;
    if (fx < 0) begin
      // rotate by 90 degrees first so the CORDIC works in the right half plane
      cx = r;
      cy = -fx;
      cz = longint'(DEG_RIGHT) <<< ANGLE_FRAC;
    end else begin
      cx = fx;
      cy = r;
      cz = 0;
    end
    for (int i = 0; i < ANGLE_ITER_DEF && i < ATAN_ENTRIES; i++) begin
      sx = cy >>> i;
      sy = cx >>> i;
      if (cy >= 0) begin
        cx = cx + sx;
        cy = cy - sy;
        cz = cz + longint'(atan_q20(i[4:0]));
      end else begin
        cx = cx - sx;
        cy = cy + sy;
        cz = cz - longint'(atan_q20(i[4:0]));
      end
    end
    deg = cz >>> ANGLE_FRAC;
    if (deg < 0) deg = 0;
    if (deg > DEG_MAX) deg = DEG_MAX;
    return int'(deg);
  endfunction

  // Advance the filter by one sample and queue the result the block must produce.
  task automatic predict_sample(input logic signed [RAW_W-1:0] xr,
                                input logic signed [RAW_W-1:0] yr,
                                input logic signed [RAW_W-1:0] zr);
    tilt_result_t res;
    longint wx, wy, wz;
    acc_x = lowpass(acc_x, xr);
    acc_y = lowpass(acc_y, yr);
    acc_z = lowpass(acc_z, zr);
    wx = acc_x >>> FRACTION_BITS_DEF;
    wy = acc_y >>> FRACTION_BITS_DEF;
    wz = acc_z >>> FRACTION_BITS_DEF;
    res.x_filt  = wx[RAW_W-1:0];
    res.y_filt  = wy[RAW_W-1:0];
    res.z_filt  = wz[RAW_W-1:0];
    res.is_zero = (acc_x == 0) && (acc_y == 0) && (acc_z == 0);
    res.angle   = res.is_zero ? '0 : ANGLE_W'(down_angle(acc_x, acc_y, acc_z));
    pending_results.push_back(res);
  endtask

  // Offer one sample, hold it until taken, then maybe drop valid for a while.
  // With no gap, valid stays high so the next call does not lower and raise it.
  task automatic send_sample(input logic signed [RAW_W-1:0] xr,
                             input logic signed [RAW_W-1:0] yr,
                             input logic signed [RAW_W-1:0] zr);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.x_raw <= xr;
    in_ch.y_raw <= yr;
    in_ch.z_raw <= zr;
    do @(posedge clk); while (!in_ch.ready);
    predict_sample(xr, yr, zr);
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold valid low and wait until every queued result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCS) @(posedge clk);
  endtask

  // Write alpha only while the block is idle.
  task automatic set_alpha(input logic [ALPHA_W-1:0] a);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_we    <= 1'b0;
    alpha_now = a;
  endtask

  function automatic logic signed [RAW_W-1:0] rand_axis();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return RAW_W'($urandom);
    if (r < 8) return RAW_W'($urandom_range(0, 4000)) - RAW_W'(2000);
    return r[0] ? 16'sh7fff : 16'sh8000;
  endfunction

  // Special cases: axis vectors, fx zero, negative fx, zero vector, field extremes.
  task automatic test_directed();
    // reset coefficient first, a few normal samples
    send_sample(16'sd0, 16'sd0, 16'sd16000);
    send_sample(16'sd11314, 16'sd0, 16'sd11314);
    set_alpha(16'hffff);
    // drive toward zero from the positive side until the vector vanishes
    repeat (4) send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd1000, 16'sd0, 16'sd0);       // on +x axis
    send_sample(-16'sd1000, 16'sd0, 16'sd0);      // on -x axis
    send_sample(16'sd0, 16'sd700, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd5000);       // fx a small negative fraction, nonzero vector
    send_sample(-16'sd5000, 16'sd3000, -16'sd2000); // negative fx
    send_sample(16'sd5000, -16'sd3000, 16'sd2000);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh7fff, 16'sh8000, 16'sh7fff);
    send_sample(16'sh8000, 16'sd1, -16'sd1);
    send_sample(16'sd20, 16'sd1, 16'sd0);         // near +x, tiny tilt
    send_sample(-16'sd20, 16'sd1, 16'sd0);        // near -x, close to 180
    set_alpha(16'd1);
    send_sample(16'sh7fff, 16'sh8000, 16'sd0);
    send_sample(16'sh8000, 16'sh7fff, 16'sd0);
  endtask

  // Random samples in phases with different coefficients, extremes included.
  task automatic test_random();
    logic [ALPHA_W-1:0] alphas[6];
    alphas[0] = ALPHA_RESET;
    alphas[1] = 16'hffff;
    alphas[2] = 16'd1;
    alphas[3] = ALPHA_W'($urandom_range(1, 65535));
    alphas[4] = ALPHA_W'($urandom_range(20000, 65535));
    alphas[5] = ALPHA_W'($urandom_range(1, 2000));
    foreach (alphas[p]) begin
      set_alpha(alphas[p]);
      repeat (330) send_sample(rand_axis(), rand_axis(), rand_axis());
    end
  endtask

  // Result side: check each accepted result, then pick the next ready level.
  initial begin
    int stall_left;
    tilt_result_t want;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (out_ch.x_filtered !== want.x_filt)
            report_mismatch($sformatf("x_filtered %0d, want %0d",
                                      out_ch.x_filtered, want.x_filt));
          if (out_ch.y_filtered !== want.y_filt)
            report_mismatch($sformatf("y_filtered %0d, want %0d",
                                      out_ch.y_filtered, want.y_filt));
          if (out_ch.z_filtered !== want.z_filt)
            report_mismatch($sformatf("z_filtered %0d, want %0d",
                                      out_ch.z_filtered, want.z_filt));
          if (out_ch.down_angle_deg !== want.angle)
            report_mismatch($sformatf("down_angle_deg %0d, want %0d",
                                      out_ch.down_angle_deg, want.angle));
          if (out_ch.zero_vector !== want.is_zero)
            report_mismatch($sformatf("zero_vector %0b, want %0b",
                                      out_ch.zero_vector, want.is_zero));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        stall_left = idle_len();
        out_ch.ready <= (stall_left == 0);
      end
    end
  end

  initial begin
    fail_count  = 0;
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    in_ch.valid <= 1'b0;
    in_ch.x_raw <= '0;
    in_ch.y_raw <= '0;
    in_ch.z_raw <= '0;
    alpha_now = ALPHA_RESET;
    acc_x = 0;
    acc_y = 0;
    acc_z = longint'(ONE_G_COUNTS) <<< FRACTION_BITS_DEF;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random();
    drain_results();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #80ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
